/* sv/hafs_pkg.sv */
// Shared types, codes and defaults for the handle allocator with free stack.
`timescale 1ns / 1ps

package hafs_pkg;

    localparam int SLOT_COUNT_DEF = 1024;

    localparam int HANDLE_W = 10;
    localparam int TAG_W    = 32;
    localparam int COUNT_W  = 10;

    localparam logic [1:0] ACT_CREATE  = 2'd0;
    localparam logic [1:0] ACT_DESTROY = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [HANDLE_W-1:0] handle_in;
        logic [TAG_W-1:0]    tag_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                create_failed;
        logic                is_live;
        logic [TAG_W-1:0]    tag_out;
        logic [COUNT_W-1:0]  live_count;
    } rsp_t;

endpackage

/* sv/hafs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hafs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/handle_allocator_free_stack_top.sv */
// Top level of the handle allocator: control, counters, tag table and free stack.
//
//   channel | signals                          | payload
//   --------+----------------------------------+-------------------
//   req     | req_valid, req_stall, req_data   | hafs_pkg::req_t
//   rsp     | rsp_valid, rsp_stall, rsp_data   | hafs_pkg::rsp_t
//
// Each item is handled first in the transfer cycle, which issues the tag table and free stack
// reads, and then in S_EXEC, which uses the registered read data and writes back.
// After reset the tag table is cleared one entry a cycle, all SLOT_COUNT entries, with
// req_stall high.
// A result waits in the output register; the write-back cycle holds while it is stalled.
`timescale 1ns / 1ps

module handle_allocator_free_stack_top #(
    parameter int SLOT_COUNT = hafs_pkg::SLOT_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  hafs_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output hafs_pkg::rsp_t rsp_data
);

    import hafs_pkg::*;

    localparam int HW = $clog2(SLOT_COUNT);
    localparam int XW = ((HW > HANDLE_W) ? HW : HANDLE_W) + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [HW-1:0]      clr_reg, clr_next;
    logic [HW:0]        depth_reg, depth_next;
    logic [HW:0]        fresh_reg, fresh_next;
    logic [COUNT_W-1:0] live_reg, live_next;
    req_t               item_reg, item_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic               req_xfer;
    logic               commit;
    logic [HANDLE_W-1:0] rd_handle;
    logic [XW-1:0]      h_ext;
    logic               h_in_range;
    logic [HW-1:0]      h_addr;

    logic               tag_we;
    logic [HW-1:0]      tag_waddr;
    logic [TAG_W-1:0]   tag_wdata;
    logic [HW-1:0]      tag_raddr;
    logic [TAG_W-1:0]   tag_rdata;

    logic               stk_we;
    logic [HW-1:0]      stk_waddr;
    logic [HW-1:0]      stk_raddr;
    logic [HW-1:0]      stk_rdata;

    logic [HW-1:0]      new_id;

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign commit    = (state_reg == S_EXEC) && !(rsp_valid_reg && rsp_stall);

    assign rd_handle  = (state_reg == S_IDLE) ? req_data.handle_in : item_reg.handle_in;
    assign h_ext      = XW'(rd_handle);
    assign h_in_range = (h_ext < XW'(SLOT_COUNT));
    assign h_addr     = h_ext[HW-1:0];
    assign tag_raddr  = h_addr;
    assign stk_raddr  = HW'(depth_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        depth_next     = depth_reg;
        fresh_next     = fresh_reg;
        live_next      = live_reg;
        item_next      = item_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        tag_we         = 1'b0;
        tag_waddr      = h_addr;
        tag_wdata      = '0;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[HW-1:0];
        new_id         = stk_rdata;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                tag_we    = 1'b1;
                tag_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == HW'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    item_next  = req_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    rsp_next = '0;
                    unique case (item_reg.action)
                        ACT_CREATE:
                        begin
                            if (depth_reg != '0)
                            begin
                                new_id     = stk_rdata;
                                depth_next = depth_reg - 1'b1;
                            end
                            else
                            begin
                                new_id = fresh_reg[HW-1:0];
                            end
                            if (depth_reg != '0 || fresh_reg < (HW+1)'(SLOT_COUNT))
                            begin
                                if (depth_reg == '0)
                                begin
                                    fresh_next = fresh_reg + 1'b1;
                                end
                                tag_we              = 1'b1;
                                tag_waddr           = new_id;
                                tag_wdata           = item_reg.tag_in;
                                live_next           = live_reg + 1'b1;
                                rsp_next.handle_out = HANDLE_W'(new_id);
                            end
                            else
                            begin
                                rsp_next.create_failed = 1'b1;
                            end
                        end
                        ACT_DESTROY:
                        begin
                            if (h_in_range && h_ext != '0 && tag_rdata != '0)
                            begin
                                tag_we = 1'b1;
                                if (depth_reg < (HW+1)'(SLOT_COUNT))
                                begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + 1'b1;
                                end
                                live_next = live_reg - 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (h_in_range)
                            begin
                                rsp_next.tag_out = tag_rdata;
                                rsp_next.is_live = (h_ext != '0) && (tag_rdata != '0);
                            end
                        end
                        default:
                        begin
                            rsp_next = '0;
                        end
                    endcase
                    rsp_next.live_count = live_next;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            depth_reg     <= '0;
            fresh_reg     <= (HW+1)'(1);
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    hafs_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SLOT_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    hafs_ram #(
        .WIDTH (HW),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (h_addr),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule
